// ===== hw/rtl/anu_pkg.sv =====
package anu_pkg;

   localparam int WinDepth          = 4;
   localparam int BufLen            = WinDepth + 1;
   localparam int LongCode          = 4;
   localparam int ShortCode         = 3;
   localparam int CodeAtLen         = BufLen + 1;
   localparam int PadLen            = CodeAtLen + LongCode - 1;
   localparam int MaxRes            = 4;
   localparam int QueueDepthDefault = 4;

   localparam logic [4:0] TypeMask  = 5'h1f;
   localparam logic [7:0] ZeroByte  = 8'h00;
   localparam logic [7:0] OneByte   = 8'h01;
   localparam logic [7:0] PadByte   = 8'hff;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       nal_first;
      logic       nal_last;
      logic [4:0] unit_type;
   } result_type;

   // one input byte's worth of results; last_idx is the count minus one
   typedef struct packed {
      logic [1:0]                   last_idx;
      result_type [MaxRes-1:0]      item;
   } group_type;

   typedef struct packed {
      logic      valid;
      group_type group;
   } head_type;

endpackage

// ===== hw/rtl/anu_if.sv =====
interface anu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       unit_last;

   modport source (output valid, output data_byte, output unit_last, input ready);
   modport sink (input valid, input data_byte, input unit_last, output ready);
endinterface

interface anu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       nal_first;
   logic       nal_last;
   logic [4:0] unit_type;
   logic       run_last;

   modport source (output valid, output payload_byte, output nal_first, output nal_last,
                   output unit_type, output run_last, input ready);
   modport sink (input valid, input payload_byte, input nal_first, input nal_last,
                 input unit_type, input run_last, output ready);
endinterface

// ===== hw/rtl/anu_front.sv =====
module anu_front
   import anu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   input  logic       queue_full,
   output logic       push,
   output group_type  push_group
);

   logic [7:0] win_ff [WinDepth];
   logic [7:0] win_in [WinDepth];
   logic [2:0] fill_ff, fill_in;
   logic       inside_ff, inside_in;
   logic [1:0] skip_ff, skip_in;
   logic       first_pend_ff, first_pend_in;
   logic [4:0] type_ff, type_in;
   logic       spill_valid_ff, spill_valid_in;
   result_type spill_ff, spill_in;

   logic       accept;
   logic [2:0] n;
   logic [7:0] win_buf [PadLen];
   logic       long_at [CodeAtLen];
   logic       short_at [CodeAtLen];
   result_type res [MaxRes+1];
   logic [2:0] cnt;
   logic       lp_inside, lp_first_pend;
   logic [1:0] lp_skip;
   logic [4:0] lp_type;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign n        = fill_ff + 3'd1;

   // window plus the new byte, padded so the code search never reads past the end
   always_comb begin
      for (int k = 0; k < PadLen; k++) begin
         if (k < WinDepth && k < int'(fill_ff)) begin
            win_buf[k] = win_ff[k];
         end else if (k < BufLen) begin
            win_buf[k] = in_byte;
         end else begin
            win_buf[k] = PadByte;
         end
      end
      for (int p = 0; p < CodeAtLen; p++) begin
         long_at[p]  = (p + LongCode <= int'(n)) && win_buf[p] == ZeroByte &&
                       win_buf[p+1] == ZeroByte && win_buf[p+2] == ZeroByte &&
                       win_buf[p+3] == OneByte;
         short_at[p] = (p + ShortCode <= int'(n)) && win_buf[p] == ZeroByte &&
                       win_buf[p+1] == ZeroByte && win_buf[p+2] == OneByte;
      end
   end

   // settle positions in order; the end of a unit flushes the whole window
   always_comb begin
      logic active;
      logic is_first;
      logic is_last;
      lp_inside     = inside_ff;
      lp_first_pend = first_pend_ff;
      lp_skip       = skip_ff;
      lp_type       = type_ff;
      cnt           = {2'b00, spill_valid_ff};
      for (int s = 0; s <= MaxRes; s++) begin
         res[s] = spill_ff;
      end
      for (int i = 0; i < BufLen; i++) begin
         active   = in_last ? (i < int'(n)) : (i == 0 && int'(n) == BufLen);
         is_first = 1'b0;
         is_last  = 1'b0;
         if (active) begin
            if (lp_skip != 2'd0) begin
               lp_skip = lp_skip - 2'd1;
            end else if (long_at[i] || short_at[i]) begin
               lp_skip       = long_at[i] ? 2'(LongCode - 1) : 2'(ShortCode - 1);
               lp_inside     = 1'b1;
               lp_first_pend = 1'b1;
            end else if (lp_inside) begin
               is_first = lp_first_pend;
               if (lp_first_pend) begin
                  lp_type       = win_buf[i][4:0] & TypeMask;
                  lp_first_pend = 1'b0;
               end
               is_last = (i + 1 >= int'(n)) || long_at[i+1] || short_at[i+1];
               if (int'(cnt) <= MaxRes) begin
                  res[cnt] = '{payload_byte: win_buf[i], nal_first: is_first,
                               nal_last: is_last, unit_type: lp_type};
               end
               cnt = cnt + 3'd1;
            end
         end
      end
   end

   always_comb begin
      push                = accept && cnt != 3'd0;
      push_group.last_idx = (int'(cnt) > MaxRes) ? 2'(MaxRes - 1) : 2'(cnt - 3'd1);
      for (int s = 0; s < MaxRes; s++) begin
         push_group.item[s] = res[s];
      end
   end

   always_comb begin
      win_in         = win_ff;
      fill_in        = fill_ff;
      inside_in      = inside_ff;
      skip_in        = skip_ff;
      first_pend_in  = first_pend_ff;
      type_in        = type_ff;
      spill_valid_in = spill_valid_ff;
      spill_in       = spill_ff;
      if (accept) begin
         spill_valid_in = int'(cnt) == MaxRes + 1;
         spill_in       = res[MaxRes];
         if (in_last) begin
            for (int k = 0; k < WinDepth; k++) begin
               win_in[k] = ZeroByte;
            end
            fill_in       = '0;
            inside_in     = 1'b0;
            skip_in       = '0;
            first_pend_in = 1'b0;
            type_in       = '0;
         end else begin
            inside_in     = lp_inside;
            skip_in       = lp_skip;
            first_pend_in = lp_first_pend;
            type_in       = lp_type;
            if (int'(n) == BufLen) begin
               for (int k = 0; k < WinDepth; k++) begin
                  win_in[k] = win_buf[k+1];
               end
               fill_in = 3'(WinDepth);
            end else begin
               win_in[fill_ff[1:0]] = in_byte;
               fill_in              = n;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      spill_ff <= spill_in;
      if (reset) begin
         for (int k = 0; k < WinDepth; k++) begin
            win_ff[k] <= ZeroByte;
         end
         fill_ff        <= '0;
         inside_ff      <= 1'b0;
         skip_ff        <= '0;
         first_pend_ff  <= 1'b0;
         type_ff        <= '0;
         spill_valid_ff <= 1'b0;
      end else begin
         win_ff         <= win_in;
         fill_ff        <= fill_in;
         inside_ff      <= inside_in;
         skip_ff        <= skip_in;
         first_pend_ff  <= first_pend_in;
         type_ff        <= type_in;
         spill_valid_ff <= spill_valid_in;
      end
   end

endmodule

// ===== hw/rtl/anu_queue.sv =====
module anu_queue
   import anu_pkg::*;
#(
   parameter int Depth = QueueDepthDefault
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  group_type push_group,
   output logic      full,
   output head_type  head,
   input  logic      pop
);

   localparam int AddrW = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);

   group_type        mem_ff [Depth];
   logic [AddrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AddrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = count_ff == CntW'(Depth);
   assign head.valid = count_ff != '0;
   assign head.group = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AddrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AddrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_group;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/anu_back.sv =====
module anu_back
   import anu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  head_type   head,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_item,
   output logic       out_run_last
);

   logic       valid_ff, valid_in;
   result_type item_ff, item_in;
   logic       run_last_ff, run_last_in;
   logic [1:0] sub_ff, sub_in;
   logic       load, done;

   assign load         = head.valid && (!valid_ff || out_ready);
   assign done         = sub_ff == head.group.last_idx;
   assign pop          = load && done;
   assign out_valid    = valid_ff;
   assign out_item     = item_ff;
   assign out_run_last = run_last_ff;

   // walk the head group one result per transfer
   always_comb begin
      valid_in    = valid_ff;
      item_in     = item_ff;
      run_last_in = run_last_ff;
      sub_in      = sub_ff;
      if (load) begin
         valid_in    = 1'b1;
         item_in     = head.group.item[sub_ff];
         run_last_in = done;
         sub_in      = done ? 2'd0 : sub_ff + 2'd1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      run_last_ff <= run_last_in;
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

endmodule

// ===== hw/rtl/annexb_nal_unit_splitter.sv =====
// Path: a payload byte is settled when the fourth byte after it is taken, or by the
//   unit's last byte; its result then goes through the group queue and rsp register.
// Throughput: one byte per cycle while results keep pace; the last byte of a unit
//   releases up to five results, drained one per cycle from the queue as rsp is ready.
// Reset: synchronous, active high; clears the window, parser state, queue and output.
module annexb_nal_unit_splitter
   import anu_pkg::*;
#(
   parameter int QueueDepth = QueueDepthDefault
) (
   input logic     clock,
   input logic     reset,
   anu_req_if.sink   req_chan,
   anu_rsp_if.source rsp_chan
);

   logic       push, full, pop;
   group_type  push_group;
   head_type   head;
   result_type out_item;

   anu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_byte    (req_chan.data_byte),
      .in_last    (req_chan.unit_last),
      .queue_full (full),
      .push       (push),
      .push_group (push_group)
   );

   anu_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .full       (full),
      .head       (head),
      .pop        (pop)
   );

   anu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .out_valid    (rsp_chan.valid),
      .out_ready    (rsp_chan.ready),
      .out_item     (out_item),
      .out_run_last (rsp_chan.run_last)
   );

   assign rsp_chan.payload_byte = out_item.payload_byte;
   assign rsp_chan.nal_first    = out_item.nal_first;
   assign rsp_chan.nal_last     = out_item.nal_last;
   assign rsp_chan.unit_type    = out_item.unit_type;

endmodule

// ===== hw/rtl/anu_checker.sv =====
module anu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_nal_first,
   input logic       rsp_nal_last,
   input logic [4:0] rsp_unit_type,
   input logic       rsp_run_last
);

   logic       xfer;
   logic       exp_first_ff;
   logic [4:0] type_ff;

   assign xfer = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_first_ff <= 1'b1;
         type_ff      <= '0;
      end else if (xfer) begin
         exp_first_ff <= rsp_nal_last;
         type_ff      <= rsp_unit_type;
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_payload_byte, rsp_nal_first,
         rsp_nal_last, rsp_unit_type, rsp_run_last}))
      else $error("rsp transfer changed while stalled");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // a NAL opens exactly after the previous one closed
   a_first_after_last: assert property (@(posedge clock) disable iff (reset)
      xfer |-> rsp_nal_first == exp_first_ff)
      else $error("nal_first out of step with nal_last");

   a_type_on_first: assert property (@(posedge clock) disable iff (reset)
      xfer && rsp_nal_first |-> rsp_unit_type == rsp_payload_byte[4:0])
      else $error("unit_type differs from header byte");

   a_type_steady: assert property (@(posedge clock) disable iff (reset)
      xfer && !rsp_nal_first |-> rsp_unit_type == type_ff)
      else $error("unit_type changed inside a NAL");

endmodule

bind annexb_nal_unit_splitter anu_checker u_anu_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_payload_byte (rsp_chan.payload_byte),
   .rsp_nal_first    (rsp_chan.nal_first),
   .rsp_nal_last     (rsp_chan.nal_last),
   .rsp_unit_type    (rsp_chan.unit_type),
   .rsp_run_last     (rsp_chan.run_last)
);
